[sv/amdt_pkg.sv]
// Package for the affine matrix dedup table: sizes, item structs and the
// token that travels down the chain of slot cells. No dependencies.
`default_nettype none

package amdt_pkg;

  // Table size and derived widths
  localparam int unsigned MaxSlots = 32;
  localparam int unsigned IdxW     = (MaxSlots > 1) ? $clog2(MaxSlots) : 1;
  localparam int unsigned CntW     = $clog2(MaxSlots + 1);
  localparam int unsigned KeyW     = 64;
  localparam int unsigned IndexW   = 5;

  // Command codes
  localparam logic CmdLookup = 1'b0;
  localparam logic CmdClear  = 1'b1;

  // Input item
  typedef struct packed {
    logic               cmd;
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] coef_c;
    logic signed [31:0] coef_d;
  } req_t;

  // Result item
  typedef struct packed {
    logic [IndexW-1:0] slot_index;
    logic              table_full;
  } res_t;

  // Lookup token handed from cell to cell
  typedef struct packed {
    logic            valid;
    logic            hit;
    logic            app;
    logic [IdxW-1:0] idx;
    logic [KeyW-1:0] key;
  } token_t;

  // Bits 19..4 of each coefficient, a in the low quarter
  function automatic logic [KeyW-1:0] pack_key(input req_t r);
    pack_key = {r.coef_d[19:4], r.coef_c[19:4], r.coef_b[19:4], r.coef_a[19:4]};
  endfunction

endpackage

`default_nettype wire

[sv/amdt_cell.sv]
// One slot cell of the dedup table chain: holds one stored key, checks the
// passing lookup token against it, claims the slot on append.
// Depends on amdt_pkg.
`default_nettype none

module amdt_cell (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [amdt_pkg::CntW-1:0] cell_idx_i,
  input  wire logic [amdt_pkg::CntW-1:0] used_i,
  input  wire amdt_pkg::token_t      tok_i,
  output amdt_pkg::token_t           tok_o
);

  logic [amdt_pkg::KeyW-1:0] key_q;
  amdt_pkg::token_t          tok_q, tok_d;
  logic                      slot_live;
  logic                      wr_en;

  assign slot_live = (cell_idx_i < used_i);

  // Match against a live slot, or take the first free slot
  always_comb begin
    tok_d = tok_i;
    wr_en = 1'b0;
    if (tok_i.valid && !tok_i.hit) begin
      if (slot_live && (key_q == tok_i.key)) begin
        tok_d.hit = 1'b1;
        tok_d.idx = cell_idx_i[amdt_pkg::IdxW-1:0];
      end else if (cell_idx_i == used_i) begin
        tok_d.hit = 1'b1;
        tok_d.app = 1'b1;
        tok_d.idx = cell_idx_i[amdt_pkg::IdxW-1:0];
        wr_en     = 1'b1;
      end
    end
  end

  // Stored key, written on append only
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_q <= tok_i.key;
    end
  end

  // Token stage toward the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

[sv/affine_matrix_dedup_table_unit.sv]
// Top level of the affine matrix dedup table: the chain of slot cells,
// slot count and result strobe. Depends on amdt_pkg and amdt_cell.
`default_nettype none

// A lookup runs from accept to result while the token passes down the
// chain of slot cells, each of which registers it. busy stays high through
// the cycle of the result strobe and falls at its end, so the next item is
// not taken before the strobe cycle has ended. A clear gives no result and
// leaves busy low. done_o marks each result for exactly one cycle; the
// receiver cannot stall and must take it then. After reset the table is
// empty and ready at once.
module affine_matrix_dedup_table_unit (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output      logic          busy,
  input  wire amdt_pkg::req_t req_i,
  output      logic          done_o,
  output amdt_pkg::res_t     res_o
);

  logic                      busy_q;
  logic [amdt_pkg::CntW-1:0] used_q;
  logic                      accept;
  amdt_pkg::token_t          chain [amdt_pkg::MaxSlots+1];
  amdt_pkg::token_t          tok_end;
  logic [amdt_pkg::IdxW+amdt_pkg::IndexW-1:0] idx_wide;

  assign busy   = busy_q;
  assign accept = start && !busy_q;

  // Token entering the first cell
  always_comb begin
    chain[0]       = '0;
    chain[0].valid = accept && (req_i.cmd == amdt_pkg::CmdLookup);
    chain[0].key   = amdt_pkg::pack_key(req_i);
  end

  // Row of slot cells
  for (genvar i = 0; i < amdt_pkg::MaxSlots; i++) begin : g_cell
    amdt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (amdt_pkg::CntW'(i)),
      .used_i     (used_q),
      .tok_i      (chain[i]),
      .tok_o      (chain[i+1])
    );
  end

  assign tok_end = chain[amdt_pkg::MaxSlots];

  // Busy flag and slot count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      used_q <= '0;
    end else begin
      if (accept && (req_i.cmd == amdt_pkg::CmdClear)) begin
        used_q <= '0;
      end else if (tok_end.valid && tok_end.app) begin
        used_q <= used_q + amdt_pkg::CntW'(1);
      end
      if (accept && (req_i.cmd == amdt_pkg::CmdLookup)) begin
        busy_q <= 1'b1;
      end else if (tok_end.valid) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Result from the token leaving the last cell; no hit means full
  assign idx_wide = {{amdt_pkg::IndexW{1'b0}}, tok_end.idx};
  assign done_o   = tok_end.valid;
  always_comb begin
    res_o = '0;
    if (tok_end.hit) begin
      res_o.slot_index = idx_wide[amdt_pkg::IndexW-1:0];
    end else begin
      res_o.table_full = 1'b1;
    end
  end

endmodule

`default_nettype wire
